@@ rtl/core/md5_pkg.sv @@
package md5_pkg;

  localparam int BlockWords = 16;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_OUT
  } state_t;

  function automatic logic [31:0] round_const(input logic [5:0] s);
    logic [31:0] k;
    begin
      unique case (s)
        6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
        6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
        6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
        6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
        6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
        6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
        6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
        6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
        6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
        6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
        6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
        6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
        6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
        6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
        6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
        6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
        6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
        6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
        6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
        6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
        6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
        6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
        6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] s);
    logic [4:0] r;
    begin
      unique case ({s[5:4], s[1:0]})
        4'h0: r = 5'd7;  4'h1: r = 5'd12; 4'h2: r = 5'd17; 4'h3: r = 5'd22;
        4'h4: r = 5'd5;  4'h5: r = 5'd9;  4'h6: r = 5'd14; 4'h7: r = 5'd20;
        4'h8: r = 5'd4;  4'h9: r = 5'd11; 4'ha: r = 5'd16; 4'hb: r = 5'd23;
        4'hc: r = 5'd6;  4'hd: r = 5'd10; 4'he: r = 5'd15; default: r = 5'd21;
      endcase
      return r;
    end
  endfunction

  // Message word used by a step.
  function automatic logic [3:0] word_index(input logic [5:0] s);
    logic [3:0] w;
    begin
      unique case (s[5:4])
        2'd0: w = s[3:0];
        2'd1: w = 4'((s[3:0] * 4'd5) + 4'd1);
        2'd2: w = 4'((s[3:0] * 4'd3) + 4'd5);
        default: w = 4'(s[3:0] * 4'd7);
      endcase
      return w;
    end
  endfunction

endpackage

@@ rtl/core/md5_if.sv @@
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  modport source (output valid, action, data_byte, input ready);
  modport sink   (input valid, action, data_byte, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word_0;
  logic [31:0] digest_word_1;
  logic [31:0] digest_word_2;
  logic [31:0] digest_word_3;
  modport source (output valid, digest_word_0, digest_word_1, digest_word_2,
                  digest_word_3, input ready);
  modport sink   (input valid, digest_word_0, digest_word_1, digest_word_2,
                  digest_word_3, output ready);
endinterface

@@ rtl/core/md5_blkmem.sv @@
// Sixteen-word block buffer: byte-lane write port, registered read port.
module md5_blkmem (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [3:0]  wr_idx,
  input  logic [3:0]  wr_lane,
  input  logic [31:0] wr_data,
  input  logic [3:0]  rd_idx,
  output logic [31:0] rd_data
);

  logic [31:0] mem [md5_pkg::BlockWords];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < 4; i++) begin
        if (wr_lane[i]) begin
          mem[wr_idx][i*8 +: 8] <= wr_data[i*8 +: 8];
        end
      end
    end
    rd_data_r <= mem[rd_idx];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/md5_round.sv @@
// One MD5 step per cycle while step_en is high, over the working registers a..d.
module md5_round (
  input  logic        clk,
  input  logic        load,
  input  logic [31:0] init_a,
  input  logic [31:0] init_b,
  input  logic [31:0] init_c,
  input  logic [31:0] init_d,
  input  logic        step_en,
  input  logic [5:0]  step,
  input  logic [31:0] msg_word,
  output logic [31:0] a,
  output logic [31:0] b,
  output logic [31:0] c,
  output logic [31:0] d
);

  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] f, t, rot;
  logic [4:0]  sh;

  always_comb begin
    unique case (step[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (b_r & d_r) | (c_r & ~d_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    t   = a_r + f + msg_word + md5_pkg::round_const(step);
    sh  = md5_pkg::rot_amount(step);
    rot = (t << sh) | (t >> (6'd32 - {1'b0, sh}));
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_r <= init_a;
      b_r <= init_b;
      c_r <= init_c;
      d_r <= init_d;
    end else if (step_en) begin
      a_r <= d_r;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= b_r + rot;
    end
  end

  assign a = a_r;
  assign b = b_r;
  assign c = c_r;
  assign d = d_r;

endmodule

@@ rtl/core/md5_message_digest.sv @@
// Channel | Direction | Payload
// in_     | sink      | action (1), data_byte (8)
// out_    | source    | digest_word_0..3 (32 each)
//
// A data byte is written into the block memory. When it fills a block,
// compression loads the working registers and issues the first memory read,
// runs 64 steps (one memory read per step) and makes one chaining update.
// A finish transaction pads byte by byte up to position 56, writes 8 length
// bytes and compresses, then holds the digest until the out_ transaction.
// Reset (rst_n low, synchronous) loads the initial chaining words and clears
// the bit count. in_ready is low while a block compresses, padding runs
// or the digest waits.
module md5_message_digest (
  input logic clk,
  input logic rst_n,
  md5_in_if.sink    in_ch,
  md5_out_if.source out_ch
);

  md5_pkg::state_t state_r, state_nxt;

  logic [31:0] h0_r, h1_r, h2_r, h3_r;
  logic [63:0] bit_cnt_r;
  logic [63:0] len_r;
  logic [5:0]  pos_r;
  logic [2:0]  len_k_r;
  logic [6:0]  cstep_r;
  logic        fin_r;
  logic        out_valid_r;
  // Set once the last length byte is written, so a compression ends the
  // message.
  logic        len_done_r;

  logic [5:0]  pos_cur;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [3:0]  rd_idx;
  logic [31:0] rd_data;
  logic [31:0] ra, rb, rc, rd;
  logic        rnd_load, rnd_en;
  logic        in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign pos_cur = (state_r == md5_pkg::ST_IDLE) ? bit_cnt_r[8:3] : pos_r;

  // Compression: cstep 0 issues the read of step 0's word; the memory data
  // for step s is there at cstep s+1. Working registers load at cstep 0.
  assign rd_idx   = md5_pkg::word_index(cstep_r[5:0]);
  assign rnd_load = (state_r == md5_pkg::ST_COMP) && (cstep_r == 7'd0);
  assign rnd_en   = (state_r == md5_pkg::ST_COMP) && (cstep_r != 7'd0);

  always_comb begin
    wr_en   = 1'b0;
    wr_byte = in_ch.data_byte;
    unique case (state_r)
      md5_pkg::ST_IDLE: begin
        wr_en   = in_fire;
        wr_byte = in_ch.action ? md5_pkg::PadByte : in_ch.data_byte;
      end
      md5_pkg::ST_PAD: begin
        wr_en   = 1'b1;
        wr_byte = 8'h00;
      end
      md5_pkg::ST_LEN: begin
        wr_en   = 1'b1;
        wr_byte = len_r[len_k_r*8 +: 8];
      end
      default: ;
    endcase
  end

  md5_blkmem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (pos_cur[5:2]),
    .wr_lane (4'b0001 << pos_cur[1:0]),
    .wr_data ({4{wr_byte}}),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  md5_round u_round (
    .clk      (clk),
    .load     (rnd_load),
    .init_a   (h0_r),
    .init_b   (h1_r),
    .init_c   (h2_r),
    .init_d   (h3_r),
    .step_en  (rnd_en),
    .step     (6'(cstep_r - 7'd1)),
    .msg_word (rd_data),
    .a        (ra),
    .b        (rb),
    .c        (rc),
    .d        (rd)
  );

  // Where to go after a byte write at pos_cur during finishing.
  function automatic md5_pkg::state_t after_fin_write(input logic [5:0] p,
                                                      input logic in_len);
    md5_pkg::state_t s;
    begin
      if (p == 6'd63) s = md5_pkg::ST_COMP;
      else if (in_len) s = md5_pkg::ST_LEN;
      else if (6'(p + 6'd1) == md5_pkg::LenPos) s = md5_pkg::ST_LEN;
      else s = md5_pkg::ST_PAD;
      return s;
    end
  endfunction

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      md5_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.action) state_nxt = after_fin_write(bit_cnt_r[8:3], 1'b0);
          else if (bit_cnt_r[8:3] == 6'd63) state_nxt = md5_pkg::ST_COMP;
        end
      end
      md5_pkg::ST_PAD: state_nxt = after_fin_write(pos_r, 1'b0);
      md5_pkg::ST_LEN: begin
        if (pos_r == 6'd63) state_nxt = md5_pkg::ST_COMP;
      end
      md5_pkg::ST_COMP: begin
        if (cstep_r == 7'd65) begin
          if (!fin_r) state_nxt = md5_pkg::ST_IDLE;
          else if (pos_r == md5_pkg::LenPos) state_nxt = md5_pkg::ST_LEN;
          else if (len_k_r == 3'd0 && pos_r == 6'd0 && len_done_r)
            state_nxt = md5_pkg::ST_OUT;
          else state_nxt = md5_pkg::ST_PAD;
        end
      end
      md5_pkg::ST_OUT: begin
        if (out_ch.ready) state_nxt = md5_pkg::ST_IDLE;
      end
      default: state_nxt = md5_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= md5_pkg::ST_IDLE;
      h0_r        <= md5_pkg::InitA;
      h1_r        <= md5_pkg::InitB;
      h2_r        <= md5_pkg::InitC;
      h3_r        <= md5_pkg::InitD;
      bit_cnt_r   <= '0;
      cstep_r     <= '0;
      fin_r       <= 1'b0;
      len_done_r  <= 1'b0;
      len_k_r     <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) pos_r <= 6'(pos_cur + 6'd1);
      unique case (state_r)
        md5_pkg::ST_IDLE: begin
          cstep_r <= '0;
          if (in_fire) begin
            if (in_ch.action) begin
              fin_r      <= 1'b1;
              len_done_r <= 1'b0;
              len_k_r    <= '0;
              len_r      <= bit_cnt_r;
            end else begin
              bit_cnt_r <= bit_cnt_r + 64'd8;
            end
          end
        end
        md5_pkg::ST_LEN: begin
          len_k_r <= 3'(len_k_r + 3'd1);
          if (len_k_r == 3'd7) len_done_r <= 1'b1;
          cstep_r <= '0;
        end
        md5_pkg::ST_PAD: cstep_r <= '0;
        md5_pkg::ST_COMP: begin
          if (cstep_r == 7'd65) begin
            h0_r    <= h0_r + ra;
            h1_r    <= h1_r + rb;
            h2_r    <= h2_r + rc;
            h3_r    <= h3_r + rd;
            cstep_r <= '0;
            if (fin_r && len_done_r) out_valid_r <= 1'b1;
          end else begin
            cstep_r <= cstep_r + 7'd1;
          end
        end
        md5_pkg::ST_OUT: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            fin_r       <= 1'b0;
            len_done_r  <= 1'b0;
            h0_r        <= md5_pkg::InitA;
            h1_r        <= md5_pkg::InitB;
            h2_r        <= md5_pkg::InitC;
            h3_r        <= md5_pkg::InitD;
            bit_cnt_r   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready          = (state_r == md5_pkg::ST_IDLE);
  assign out_ch.valid         = out_valid_r && (state_r == md5_pkg::ST_OUT);
  assign out_ch.digest_word_0 = h0_r;
  assign out_ch.digest_word_1 = h1_r;
  assign out_ch.digest_word_2 = h2_r;
  assign out_ch.digest_word_3 = h3_r;

endmodule

@@ dv/md5_tb_if.sv @@
`timescale 1ns / 100ps

// Testbench-side digest type, kept in its own file after the package.
// The block's own interfaces are used for the connection; this file holds the
// digest struct that the checker uses for its expected values.
package md5_tb_pkg;

  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
  } digest_t;

endpackage

@@ dv/md5_digest_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels, runs its own MD5 engine on every accepted input
// transaction and compares each digest with the oldest expected one.
module md5_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_w0,
  input  logic [31:0] out_w1,
  input  logic [31:0] out_w2,
  input  logic [31:0] out_w3,
  output int          fail_count,
  output int          pending
);

  localparam logic [31:0] StepConst [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

  localparam int Shift [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                4, 11, 16, 23, 6, 10, 15, 21};

  logic [31:0]           chain [4];
  logic [7:0]            blk_bytes [64];
  logic [63:0]           bit_count;
  md5_tb_pkg::digest_t   digest_q [$];

  function automatic logic [31:0] rol(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] a, b, c, d, f, t, m;
    int g;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int s = 0; s < 64; s++) begin
      case (s / 16)
        0: begin f = (b & c) | (~b & d); g = s; end
        1: begin f = (b & d) | (c & ~d); g = (5 * s + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * s + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * s) % 16; end
      endcase
      m = {blk_bytes[4*g+3], blk_bytes[4*g+2], blk_bytes[4*g+1], blk_bytes[4*g]};
      t = a + f + m + StepConst[s];
      a = d; d = c; c = b;
      b = b + rol(t, Shift[(s / 16) * 4 + s % 4]);
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic put_byte(input int pos, input logic [7:0] v);
    blk_bytes[pos] = v;
    if (pos == 63) compress();
  endtask

  task automatic restart();
    chain[0] = md5_pkg::InitA; chain[1] = md5_pkg::InitB;
    chain[2] = md5_pkg::InitC; chain[3] = md5_pkg::InitD;
    foreach (blk_bytes[i]) blk_bytes[i] = '0;
    bit_count = '0;
  endtask

  task automatic absorb(input logic act, input logic [7:0] byte_in);
    int pos;
    logic [63:0] len;
    pos = int'(bit_count[8:3]);
    if (!act) begin
      put_byte(pos, byte_in);
      bit_count += 64'd8;
    end else begin
      len = bit_count;
      put_byte(pos, md5_pkg::PadByte);
      pos = (pos + 1) % 64;
      while (pos != int'(md5_pkg::LenPos)) begin
        put_byte(pos, 8'h00);
        pos = (pos + 1) % 64;
      end
      for (int k = 0; k < 8; k++) begin
        put_byte(pos, len[8*k +: 8]);
        pos = (pos + 1) % 64;
      end
      digest_q.push_back('{chain[0], chain[1], chain[2], chain[3]});
      restart();
    end
  endtask

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    $display("%0t: mismatch %s got %08h expected %08h", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    restart();
  end

  assign pending = digest_q.size();

  always @(posedge clk) begin
    md5_tb_pkg::digest_t exp_d;
    if (!rst_n) begin
      restart();
      digest_q.delete();
    end else begin
      if (in_valid && in_ready) absorb(in_action, in_data_byte);
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          report("digest with none expected", out_w0, 32'h0);
        end else begin
          exp_d = digest_q.pop_front();
          if (out_w0 !== exp_d.w0) report("digest_word_0", out_w0, exp_d.w0);
          if (out_w1 !== exp_d.w1) report("digest_word_1", out_w1, exp_d.w1);
          if (out_w2 !== exp_d.w2) report("digest_word_2", out_w2, exp_d.w2);
          if (out_w3 !== exp_d.w3) report("digest_word_3", out_w3, exp_d.w3);
        end
      end
    end
  end

endmodule

@@ dv/tb_md5_message_digest.sv @@
`timescale 1ns / 100ps

// Top of the MD5 testbench. It drives byte and finish transactions, applies
// back-pressure on the digest channel and gives the verdict; all prediction
// and comparison happen in the checker instance.
module tb_md5_message_digest;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;

  // Idling probabilities in percent, changed between phases.
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   hold_off;

  md5_in_if  in_ch ();
  md5_out_if out_ch ();

  md5_message_digest i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  md5_digest_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_action   (in_ch.action),
    .in_data_byte(in_ch.data_byte),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_w0      (out_ch.digest_word_0),
    .out_w1      (out_ch.digest_word_1),
    .out_w2      (out_ch.digest_word_2),
    .out_w3      (out_ch.digest_word_3),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver decides its ready once per clock edge. During the hold-off
  // stretch it stays low so that a digest waits and the block stops taking
  // input bytes.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // One transaction: an optional run of idle cycles, then valid held high
  // until the block takes it. Valid is only lowered when no transaction follows
  // directly, so it is never dropped and raised within one time step.
  task automatic send(input logic act, input logic [7:0] byte_in);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.data_byte <= byte_in;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // A message of the given length with random content, then its finish.
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send(1'b0, 8'($urandom));
    send(1'b1, 8'($urandom));
  endtask

  // Random message lengths favor the block boundaries, where padding either
  // fits in the last block or spills into one more.
  function automatic int pick_len();
    case ($urandom_range(5))
      0: return $urandom_range(3);
      1: return 55 + $urandom_range(2);
      2: return 63 + $urandom_range(2);
      3: return 119 + $urandom_range(2);
      default: return $urandom_range(130);
    endcase
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    int sent;
    int phase_pct [4][2] = '{'{0, 0}, '{47, 0}, '{0, 47}, '{23, 23}};
    in_ch.valid     = 1'b0;
    in_ch.action    = 1'b0;
    in_ch.data_byte = 8'h00;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off        = 1'b0;
    rst_n           = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: the empty message, a repeated finish, a finish whose
    // byte field is set, short messages (one of extreme byte values) and
    // random-content lengths at the padding boundaries.
    send(1'b1, 8'hff);
    send(1'b1, 8'h00);
    send(1'b0, 8'h00);
    send(1'b0, 8'hff);
    send(1'b1, 8'haa);
    for (int i = 0; i < 3; i++) send(1'b0, 8'h55);
    send(1'b1, 8'h00);
    send_message(55);
    send_message(56);
    send_message(64);

    // Back-pressure: keep the digest channel closed for a long stretch while
    // messages keep coming, so the block must stall its input.
    hold_off <= 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off <= 1'b0;
      end
      begin
        send_message(2);
        send_message(5);
      end
    join
    wait_drained();

    // Random part, in phases of different idling on both sides.
    sent = 0;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_pct[p][0];
      recv_stall_pct = phase_pct[p][1];
      while (sent < (p + 1) * 400) begin
        int len;
        len = pick_len();
        send_message(len);
        sent += len + 1;
      end
      wait_drained();
    end
    // Some noise: finishes and bytes mixed with no structure.
    for (int i = 0; i < 60; i++) send($urandom_range(3) == 0, 8'($urandom));
    send(1'b1, 8'h00);
    wait_drained();

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #8000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/md5_pkg.sv
rtl/core/md5_if.sv
rtl/core/md5_blkmem.sv
rtl/core/md5_round.sv
rtl/core/md5_message_digest.sv
dv/md5_tb_if.sv
dv/md5_digest_checker.sv
dv/tb_md5_message_digest.sv
